/* hw/rtl/qtg_pkg.sv */
// ----------------------------------------------------------------------------
// qtg_pkg: shared types and constants of the quintic trajectory generator
// Register indexes, phase codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package qtg_pkg;

    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FINAL_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FINAL_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FINAL_Z = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DURATION = 3'd6;

    localparam logic [1:0] PHASE_BEFORE = 2'd0;
    localparam logic [1:0] PHASE_MOVING = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

    // classified word passed from front to back
    typedef struct packed {
        logic [1:0]  phase;
        logic [30:0] tick;
    } t_item;

endpackage

/* hw/rtl/qtg_front.sv */
// ----------------------------------------------------------------------------
// qtg_front: command intake
// Classifies each tick against the duration and pushes it into a short queue.
// ----------------------------------------------------------------------------
module qtg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_tick_count,
    input  logic [23:0]         i_dur,
    input  logic                i_pop,
    output logic                o_busy,
    output logic                o_valid,
    output qtg_pkg::t_item      o_item
);
    import qtg_pkg::*;

    localparam int DEPTH = 4;

    t_item       r_q [DEPTH];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        push;
    t_item       item;
    logic [23:0] dur_eff;

    // a zero duration behaves as one tick
    assign dur_eff = (i_dur == 24'd0) ? 24'd1 : i_dur;

    always_comb begin
        item.tick = i_tick_count[30:0];
        if (i_tick_count[31]) begin
            item.phase = PHASE_BEFORE;
        end else if ({1'b0, i_tick_count[30:0]} > {8'd0, dur_eff}) begin
            item.phase = PHASE_DONE;
        end else begin
            item.phase = PHASE_MOVING;
        end
    end

    assign o_busy = (r_cnt == 3'(DEPTH));
    assign push = i_start && !o_busy;
    assign o_valid = (r_cnt != 3'd0);
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(i_pop);
        end
    end

endmodule

/* hw/rtl/qtg_back.sv */
// ----------------------------------------------------------------------------
// qtg_back: trajectory evaluation
// Sequencer over a shared 64x64 multiplier, built from 32x32 partial products,
// and a restoring divider; produces position and velocity for three axes.
// ----------------------------------------------------------------------------
module qtg_back #(
    parameter int TICK_RATE_HZ = 1000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  qtg_pkg::t_item      i_item,
    output logic                o_pop,
    input  logic signed [31:0]  i_start_x,
    input  logic signed [31:0]  i_start_y,
    input  logic signed [31:0]  i_start_z,
    input  logic signed [31:0]  i_final_x,
    input  logic signed [31:0]  i_final_y,
    input  logic signed [31:0]  i_final_z,
    input  logic [23:0]         i_dur,
    output logic                o_done,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [31:0]  o_vel_x,
    output logic signed [31:0]  o_vel_y,
    output logic signed [31:0]  o_vel_z,
    output logic [1:0]          o_motion_phase
);
    import qtg_pkg::*;

    localparam logic [17:0] RATE = 18'(TICK_RATE_HZ);
    localparam logic [63:0] ONE = 64'd1 << 30;
    localparam logic [63:0] HALF = 64'd1 << 29;

    // sequencer steps
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DIVS = 5'd1;
    localparam logic [4:0] S_MUL  = 5'd2;
    localparam logic [4:0] S_MULW = 5'd3;
    localparam logic [4:0] S_DIVV = 5'd4;
    localparam logic [4:0] S_OUT  = 5'd5;

    logic [4:0]  r_st;
    logic [4:0]  r_op;       // micro-op index within multiply list
    logic [1:0]  r_ax;       // axis under work
    logic [1:0]  r_ph;
    logic [23:0] r_dur;
    logic [63:0] r_s, r_s2, r_h, r_g;
    logic [32:0] r_ad;
    logic        r_neg;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];

    // multiplier: 64x64 low 128 over four 32x32 partial products
    logic [63:0] r_ma, r_mb;
    logic [1:0]  r_mk;
    logic [127:0] r_macc;
    logic [31:0] pa, pb;
    logic [63:0] pp;

    // divider: restoring, one quotient bit per cycle, 80-bit dividend
    logic [79:0] r_dq;
    logic [24:0] r_dr;
    logic [6:0]  r_dc;
    logic [24:0] dtrial;

    logic signed [31:0] sel_start, sel_final;
    logic signed [32:0] dd;
    logic [32:0] ad_now;

    logic [63:0] opa, opb;
    logic [63:0] hk;
    logic [63:0] prod_q30;
    logic [63:0] pm;
    logic signed [33:0] psum;
    logic [79:0] vmag;

    always_comb begin
        unique case (r_ax)
            2'd0: begin sel_start = i_start_x; sel_final = i_final_x; end
            2'd1: begin sel_start = i_start_y; sel_final = i_final_y; end
            default: begin sel_start = i_start_z; sel_final = i_final_z; end
        endcase
        dd = 33'(sel_final) - 33'(sel_start);
        ad_now = dd[32] ? 33'(-dd) : 33'(dd);
    end

    assign pa = r_mk[0] ? r_ma[63:32] : r_ma[31:0];
    assign pb = r_mk[1] ? r_mb[63:32] : r_mb[31:0];
    assign pp = 64'(pa) * 64'(pb);
    assign dtrial = {r_dr[23:0], r_dq[79]} - {1'b0, r_dur};

    assign o_pop = (r_st == S_IDLE) && i_valid;

    assign prod_q30 = r_macc[93:30];
    assign pm = (r_macc[63:0] + HALF) >> 30;
    assign psum = 34'(sel_start) + (r_neg ? -34'(pm[32:0]) : 34'(pm[32:0]));
    assign vmag = (r_dq + 80'(HALF)) >> 30;

    // operand pairs for each multiply step; the product just finished is
    // taken straight from the accumulator
    always_comb begin
        hk = 10 * ONE - 15 * r_s + 6 * r_s2;
        unique case (r_op)
            5'd0: begin opa = r_s;  opb = r_s; end
            5'd1: begin opa = prod_q30; opb = r_s; end
            5'd2: begin opa = prod_q30; opb = hk; end
            5'd3: begin opa = ONE - r_s; opb = ONE - r_s; end
            5'd4: begin opa = r_s2; opb = prod_q30; end
            5'd5: begin opa = 64'(ad_now); opb = r_h; end
            5'd6: begin opa = 64'(r_ad); opb = r_g; end
            default: begin opa = r_macc[63:0]; opb = 64'(RATE); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    r_ph <= i_item.phase;
                    r_dur <= (i_dur == 24'd0) ? 24'd1 : i_dur;
                    // tick << 30 sits in the top 54 bits
                    r_dq <= {i_item.tick[23:0], 56'd0};
                    r_dr <= '0;
                    r_dc <= 7'd54;
                    r_ax <= 2'd0;
                    r_st <= (i_item.phase == PHASE_MOVING) ? S_DIVS : S_OUT;
                end
            end
            S_DIVS, S_DIVV: begin
                if (r_dc == 7'd0) begin
                    if (r_st == S_DIVS) begin
                        r_s <= r_dq[63:0];
                        r_op <= 5'd0;
                        r_st <= S_MUL;
                    end else begin
                        r_vel[r_ax] <= r_neg
                            ? ((vmag >= 80'h8000_0000) ? 32'sh8000_0000 : -32'(vmag))
                            : ((vmag > 80'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(vmag));
                        if (r_ax == 2'd2) begin
                            r_st <= S_OUT;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                            r_op <= 5'd5;
                            r_st <= S_MUL;
                        end
                    end
                end else begin
                    if (!dtrial[24]) begin
                        r_dr <= dtrial;
                        r_dq <= {r_dq[78:0], 1'b1};
                    end else begin
                        r_dr <= {r_dr[23:0], r_dq[79]};
                        r_dq <= {r_dq[78:0], 1'b0};
                    end
                    r_dc <= r_dc - 7'd1;
                end
            end
            S_MUL: begin
                // operand latch; axis magnitude set for per-axis steps
                r_ma <= opa;
                r_mb <= opb;
                r_mk <= 2'd0;
                r_macc <= '0;
                if (r_op == 5'd5) begin
                    r_neg <= dd[32];
                    r_ad <= ad_now;
                end
                r_st <= (r_op == 5'd8) ? S_DIVV : S_MULW;
            end
            S_MULW: begin
                r_macc <= r_macc + (128'(pp) << (32 * (32'(r_mk[0]) + 32'(r_mk[1]))));
                r_mk <= r_mk + 2'd1;
                if (r_mk == 2'd3) begin
                    r_st <= S_MUL;
                    r_op <= r_op + 5'd1;
                end
            end
            default: begin
                o_done <= 1'b1;
                r_st <= S_IDLE;
            end
        endcase

        // retire a finished product (in the cycle after the fourth partial is accumulated)
        if (r_st == S_MUL) begin
            unique case (r_op)
                5'd1: r_s2 <= prod_q30;
                5'd3: r_h <= (prod_q30 > ONE) ? ONE : prod_q30;
                5'd5: begin
                    // g is shared by all axes; later axes arrive here with n*rate
                    if (r_ax == 2'd0) r_g <= 30 * prod_q30;
                end
                5'd6: begin
                    r_pos[r_ax] <= (psum > 34'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                   (psum < -34'sh8000_0000) ? 32'sh8000_0000 :
                                   32'(psum);
                end
                5'd8: begin
                    // n*rate / dur, rounded in Q30
                    r_dq <= r_macc[79:0];
                    r_dr <= '0;
                    r_dc <= 7'd80;
                end
                default: ;
            endcase
        end

        if (r_st == S_OUT) begin
            o_motion_phase <= r_ph;
            unique case (r_ph)
                PHASE_BEFORE: begin
                    o_pos_x <= i_start_x; o_pos_y <= i_start_y; o_pos_z <= i_start_z;
                    o_vel_x <= '0; o_vel_y <= '0; o_vel_z <= '0;
                end
                PHASE_DONE: begin
                    o_pos_x <= i_final_x; o_pos_y <= i_final_y; o_pos_z <= i_final_z;
                    o_vel_x <= '0; o_vel_y <= '0; o_vel_z <= '0;
                end
                default: begin
                    o_pos_x <= r_pos[0]; o_pos_y <= r_pos[1]; o_pos_z <= r_pos[2];
                    o_vel_x <= r_vel[0]; o_vel_y <= r_vel[1]; o_vel_z <= r_vel[2];
                end
            endcase
        end

        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_done <= 1'b0;
        end
    end

endmodule

/* hw/rtl/quintic_trajectory_generator_unit.sv */
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_unit: 3-axis quintic setpoint generator
// Registers, command intake queue and evaluation sequencer.
// ----------------------------------------------------------------------------
// A start with busy low issues one tick; its result appears later for one
// cycle with o_done high, in issue order. A tick outside the motion goes from
// the idle step straight to the output step. A tick inside runs the divider
// for s, five shared multiplies, then per axis three multiplies, a load step
// and a velocity divide, and then the output step. The sequencer takes the
// next queued tick only when back in its idle step. It is built on the single
// shared multiplier and restoring divider. Up to four ticks queue ahead of the
// sequencer. The receiver cannot stall: o_done results must be taken when
// shown. Write registers only while no tick is in flight.
module quintic_trajectory_generator_unit #(
    parameter int TICK_RATE_HZ = 1000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [31:0]  i_tick_count,
    output logic                o_done,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [31:0]  o_vel_x,
    output logic signed [31:0]  o_vel_y,
    output logic signed [31:0]  o_vel_z,
    output logic [1:0]          o_motion_phase
);
    import qtg_pkg::*;

    logic signed [31:0] r_sx, r_sy, r_sz, r_fx, r_fy, r_fz;
    logic [23:0] r_dur;
    logic        q_valid, pop;
    t_item       q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0; r_sz <= '0;
            r_fx <= '0; r_fy <= '0; r_fz <= '0;
            r_dur <= 24'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_X: r_sx <= i_cfg_data;
                REG_START_Y: r_sy <= i_cfg_data;
                REG_START_Z: r_sz <= i_cfg_data;
                REG_FINAL_X: r_fx <= i_cfg_data;
                REG_FINAL_Y: r_fy <= i_cfg_data;
                REG_FINAL_Z: r_fz <= i_cfg_data;
                REG_DURATION: r_dur <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    qtg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_tick_count(i_tick_count), .i_dur(r_dur), .i_pop(pop),
        .o_busy(busy), .o_valid(q_valid), .o_item(q_item)
    );

    qtg_back #(.TICK_RATE_HZ(TICK_RATE_HZ)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_pop(pop),
        .i_start_x(r_sx), .i_start_y(r_sy), .i_start_z(r_sz),
        .i_final_x(r_fx), .i_final_y(r_fy), .i_final_z(r_fz),
        .i_dur(r_dur), .o_done(o_done),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_vel_x(o_vel_x), .o_vel_y(o_vel_y), .o_vel_z(o_vel_z),
        .o_motion_phase(o_motion_phase)
    );

endmodule
